// ----- rtl/pff_pkg.sv -----
// Shared widths, types and axis codes for the plane frame unit.
package pff_pkg;

   localparam int FIELD_W = 32;

   typedef logic signed [FIELD_W-1:0] coord_type;
   typedef logic [2:0][FIELD_W-1:0] vec3_type;
   typedef logic [1:0] axis_sel_type;

   localparam axis_sel_type AXIS_X = 2'd0;
   localparam axis_sel_type AXIS_Y = 2'd1;
   localparam axis_sel_type AXIS_Z = 2'd2;

endpackage

// ----- rtl/pff_if.sv -----
// Request and response channel interfaces of the plane frame unit.
interface pff_req_if;
   logic valid;
   logic ready;
   pff_pkg::coord_type origin_x;
   pff_pkg::coord_type origin_y;
   pff_pkg::coord_type origin_z;
   pff_pkg::coord_type normal_x;
   pff_pkg::coord_type normal_y;
   pff_pkg::coord_type normal_z;

   modport source (
      output valid, origin_x, origin_y, origin_z, normal_x, normal_y, normal_z,
      input ready
   );
   modport sink (
      input valid, origin_x, origin_y, origin_z, normal_x, normal_y, normal_z,
      output ready
   );
endinterface

interface pff_rsp_if;
   logic valid;
   logic ready;
   pff_pkg::coord_type frame_origin_x;
   pff_pkg::coord_type frame_origin_y;
   pff_pkg::coord_type frame_origin_z;
   pff_pkg::coord_type xaxis_x;
   pff_pkg::coord_type xaxis_y;
   pff_pkg::coord_type xaxis_z;
   pff_pkg::coord_type yaxis_x;
   pff_pkg::coord_type yaxis_y;
   pff_pkg::coord_type yaxis_z;
   pff_pkg::coord_type zaxis_x;
   pff_pkg::coord_type zaxis_y;
   pff_pkg::coord_type zaxis_z;

   modport source (
      output valid, frame_origin_x, frame_origin_y, frame_origin_z,
      xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
      zaxis_x, zaxis_y, zaxis_z,
      input ready
   );
   modport sink (
      input valid, frame_origin_x, frame_origin_y, frame_origin_z,
      xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
      zaxis_x, zaxis_y, zaxis_z,
      output ready
   );
endinterface

// ----- rtl/pff_unit_vec.sv -----
// Pipelined fixed-point vector normalizer with digit-serial square root and division.
module pff_unit_vec #(
   parameter int AXIS_FRAC_BITS = 30,
   parameter int PAY_W = 96
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pff_pkg::vec3_type      in_mag,
   input  logic [2:0]             in_neg,
   input  logic [PAY_W-1:0]       in_pay,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pff_pkg::vec3_type      out_axis,
   output logic [PAY_W-1:0]       out_pay
);

   localparam int QW = AXIS_FRAC_BITS + 2;
   localparam int SQ_END = 37;
   localparam int LEN_ST = 37;
   localparam int OUT_ST = LEN_ST + QW + 1;
   localparam int NS = OUT_ST + 1;
   localparam logic [31:0] AXIS_ONE = 32'(64'd1 << AXIS_FRAC_BITS);

   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             zero;
      logic [4:0]       sh;
      logic [31:0]      mx;
      logic [2:0][63:0] sq;
      logic [63:0]      rad;
      logic [34:0]      rem;
      logic [31:0]      root;
      logic [2:0][63:0] dr;
      logic [2:0][31:0] q;
      logic [PAY_W-1:0] pay;
   } stage_type;

   stage_type st_ff [NS];
   stage_type st_in [NS];
   logic [NS-1:0] v_ff;
   logic [NS-1:0] vin;
   wire  [NS:0]   en;

   assign en[NS] = out_ready;
   assign en[NS-1:0] = ~v_ff | en[NS:1];
   assign vin = {v_ff[NS-2:0], in_valid};
   assign in_ready = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_axis = st_ff[NS-1].q;
   assign out_pay = st_ff[NS-1].pay;

   always_comb begin
      logic [31:0] m01;
      st_in[0] = '0;
      st_in[0].mag = in_mag;
      st_in[0].neg = in_neg;
      st_in[0].pay = in_pay;
      m01 = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
      st_in[0].mx = (m01 > in_mag[2]) ? m01 : in_mag[2];
   end

   for (genvar g = 1; g < NS; g++) begin : g_st
      localparam int DJ = (g > LEN_ST && g < OUT_ST) ? (QW - 1 - (g - LEN_ST - 1)) : 0;
      always_comb begin
         stage_type   nx;
         logic [34:0] rem_t;
         logic [34:0] trial;
         logic [63:0] dvs;
         logic [31:0] cap;
         nx = st_ff[g-1];
         rem_t = '0;
         trial = '0;
         dvs = '0;
         cap = '0;
         if (g == 1) begin
            nx.zero = (nx.mx == '0);
            nx.sh = '0;
            if (nx.mx[31:30] == 2'b00) begin
               for (int b = 0; b < 30; b++) begin
                  if (nx.mx[b]) begin
                     nx.sh = 5'(30 - b);
                  end
               end
            end
         end else if (g == 2) begin
            for (int i = 0; i < 3; i++) begin
               nx.mag[i] = nx.mag[i] << nx.sh;
            end
         end else if (g == 3) begin
            for (int i = 0; i < 3; i++) begin
               nx.sq[i] = {32'd0, nx.mag[i]} * {32'd0, nx.mag[i]};
            end
         end else if (g == 4) begin
            nx.rad = nx.sq[0] + nx.sq[1] + nx.sq[2];
            nx.rem = '0;
            nx.root = '0;
         end else if (g < SQ_END + 1 && g > 4 && g < LEN_ST) begin
            rem_t = {nx.rem[32:0], nx.rad[63:62]};
            trial = {1'b0, nx.root, 2'b01};
            if (rem_t >= trial) begin
               nx.rem = rem_t - trial;
               nx.root = {nx.root[30:0], 1'b1};
            end else begin
               nx.rem = rem_t;
               nx.root = {nx.root[30:0], 1'b0};
            end
            nx.rad = {nx.rad[61:0], 2'b00};
         end else if (g == LEN_ST) begin
            for (int i = 0; i < 3; i++) begin
               nx.dr[i] = ({32'd0, nx.mag[i]} << AXIS_FRAC_BITS) + {33'd0, nx.root[31:1]};
            end
            nx.q = '0;
         end else if (g < OUT_ST) begin
            dvs = {32'd0, nx.root} << DJ;
            for (int i = 0; i < 3; i++) begin
               if (nx.dr[i] >= dvs) begin
                  nx.dr[i] = nx.dr[i] - dvs;
                  nx.q[i][DJ] = 1'b1;
               end
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               cap = (nx.q[i] > AXIS_ONE) ? AXIS_ONE : nx.q[i];
               nx.q[i] = nx.neg[i] ? (~cap + 32'd1) : cap;
            end
            if (nx.zero) begin
               nx.q[0] = '0;
               nx.q[1] = '0;
               nx.q[2] = AXIS_ONE;
            end
         end
         st_in[g] = nx;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NS; g++) begin
         if (en[g]) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int g = 0; g < NS; g++) begin
            if (en[g]) begin
               v_ff[g] <= vin[g];
            end
         end
      end
   end

endmodule

// ----- rtl/plane_frame_from_normal_unit.sv -----
// Top level of the plane frame unit: builds an orthonormal frame from an origin and a normal.
// The unit takes one item per cycle unless back-pressure from the response side holds it, and
// returns one result per item, in order. Each of the two normalizers has AXIS_FRAC_BITS + 41
// stages, made of a 32-stage square root, an (AXIS_FRAC_BITS+2)-stage divider, one result bit
// per stage, and seven stages of scaling, squaring and sign handling; seven more stages handle
// axis selection, projection and the cross product. Any stage that holds no item takes a new
// one, so bubbles close up under back-pressure. The origin passes through; axis outputs are
// Q2.AXIS_FRAC_BITS.
module plane_frame_from_normal_unit #(
   parameter int AXIS_FRAC_BITS = 30
) (
   input  logic           clock,
   input  logic           reset,
   pff_req_if.sink        req_chan,
   pff_rsp_if.source      rsp_chan
);

   localparam logic [31:0] AXIS_ONE = 32'(64'd1 << AXIS_FRAC_BITS);
   localparam logic [63:0] HALF64 = 64'd1 << (AXIS_FRAC_BITS - 1);
   localparam logic [64:0] HALF65 = 65'd1 << (AXIS_FRAC_BITS - 1);

   pff_pkg::vec3_type n_mag;
   logic [2:0]        n_neg;
   logic              uv1_out_valid;
   pff_pkg::vec3_type uv1_axis;
   logic [95:0]       uv1_pay;
   logic              uv2_in_ready;
   logic              uv2_out_valid;
   pff_pkg::vec3_type uv2_axis;
   logic [191:0]      uv2_pay;
   logic              en_a, en_b, en_c, en_d, en_e, en_f, en_g;

   pff_pkg::vec3_type       za_ff, zb_ff, zc_ff, zd_ff;
   logic [95:0]             oa_ff, ob_ff, oc_ff, od_ff, oe_ff, of_ff;
   pff_pkg::axis_sel_type   ka_ff, kb_ff, kc_ff, ka_in;
   logic signed [2:0][63:0] prod_ff, prod_in;
   logic [2:0][31:0]        rmag_ff, rmag_in;
   logic [2:0]              rneg_ff, rneg_in;
   pff_pkg::vec3_type       pmag_ff, pmag_in;
   logic [2:0]              pneg_ff, pneg_in;
   pff_pkg::vec3_type       xe_ff, xf_ff, ze_ff, zf_ff;
   logic signed [5:0][63:0] t_ff, t_in;
   logic signed [2:0][64:0] d_ff, d_in;
   pff_pkg::vec3_type       y_in;
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff;
   pff_pkg::vec3_type       og_ff, xg_ff, yg_ff, zg_ff;

   assign n_neg = {req_chan.normal_z[31], req_chan.normal_y[31], req_chan.normal_x[31]};
   assign n_mag[0] = n_neg[0] ? (~req_chan.normal_x + 32'd1) : req_chan.normal_x;
   assign n_mag[1] = n_neg[1] ? (~req_chan.normal_y + 32'd1) : req_chan.normal_y;
   assign n_mag[2] = n_neg[2] ? (~req_chan.normal_z + 32'd1) : req_chan.normal_z;

   pff_unit_vec #(
      .AXIS_FRAC_BITS(AXIS_FRAC_BITS),
      .PAY_W(96)
   ) u_norm_z (
      .clock(clock),
      .reset(reset),
      .in_valid(req_chan.valid),
      .in_ready(req_chan.ready),
      .in_mag(n_mag),
      .in_neg(n_neg),
      .in_pay({req_chan.origin_x, req_chan.origin_y, req_chan.origin_z}),
      .out_valid(uv1_out_valid),
      .out_ready(en_a),
      .out_axis(uv1_axis),
      .out_pay(uv1_pay)
   );

   assign en_g = !vg_ff || rsp_chan.ready;
   assign en_f = !vf_ff || en_g;
   assign en_e = !ve_ff || en_f;
   assign en_d = !vd_ff || uv2_in_ready;
   assign en_c = !vc_ff || en_d;
   assign en_b = !vb_ff || en_c;
   assign en_a = !va_ff || en_b;

   // Reference axis: the one least aligned with the normal, ties to the lower axis.
   always_comb begin
      logic [31:0] a0, a1, a2;
      a0 = uv1_axis[0][31] ? (~uv1_axis[0] + 32'd1) : uv1_axis[0];
      a1 = uv1_axis[1][31] ? (~uv1_axis[1] + 32'd1) : uv1_axis[1];
      a2 = uv1_axis[2][31] ? (~uv1_axis[2] + 32'd1) : uv1_axis[2];
      if (a0 <= a1 && a0 <= a2) begin
         ka_in = pff_pkg::AXIS_X;
      end else if (a1 <= a2) begin
         ka_in = pff_pkg::AXIS_Y;
      end else begin
         ka_in = pff_pkg::AXIS_Z;
      end
   end

   always_comb begin
      logic [31:0] zk;
      zk = za_ff[ka_ff];
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed(zk) * $signed(za_ff[i]);
      end
   end

   always_comb begin
      logic [63:0] pm;
      logic [63:0] pr;
      for (int i = 0; i < 3; i++) begin
         pm = prod_ff[i][63] ? (~prod_ff[i] + 64'd1) : prod_ff[i];
         pr = (pm + HALF64) >> AXIS_FRAC_BITS;
         rmag_in[i] = pr[31:0];
         rneg_in[i] = prod_ff[i][63];
      end
   end

   always_comb begin
      logic [33:0] base;
      logic [33:0] sr;
      logic [33:0] pv;
      for (int i = 0; i < 3; i++) begin
         base = (kc_ff == 2'(i)) ? {2'b00, AXIS_ONE} : 34'd0;
         sr = rneg_ff[i] ? (~{2'b00, rmag_ff[i]} + 34'd1) : {2'b00, rmag_ff[i]};
         pv = base - sr;
         pneg_in[i] = pv[33];
         pmag_in[i] = pv[33] ? 32'(~pv + 34'd1) : pv[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         za_ff <= uv1_axis;
         oa_ff <= uv1_pay;
         ka_ff <= ka_in;
      end
      if (en_b) begin
         zb_ff <= za_ff;
         ob_ff <= oa_ff;
         kb_ff <= ka_ff;
         prod_ff <= prod_in;
      end
      if (en_c) begin
         zc_ff <= zb_ff;
         oc_ff <= ob_ff;
         kc_ff <= kb_ff;
         rmag_ff <= rmag_in;
         rneg_ff <= rneg_in;
      end
      if (en_d) begin
         zd_ff <= zc_ff;
         od_ff <= oc_ff;
         pmag_ff <= pmag_in;
         pneg_ff <= pneg_in;
      end
   end

   pff_unit_vec #(
      .AXIS_FRAC_BITS(AXIS_FRAC_BITS),
      .PAY_W(192)
   ) u_norm_x (
      .clock(clock),
      .reset(reset),
      .in_valid(vd_ff),
      .in_ready(uv2_in_ready),
      .in_mag(pmag_ff),
      .in_neg(pneg_ff),
      .in_pay({od_ff, zd_ff}),
      .out_valid(uv2_out_valid),
      .out_ready(en_e),
      .out_axis(uv2_axis),
      .out_pay(uv2_pay)
   );

   // Cross product y = z x x.
   always_comb begin
      pff_pkg::vec3_type z;
      z = uv2_pay[95:0];
      t_in[0] = $signed(z[1]) * $signed(uv2_axis[2]);
      t_in[1] = $signed(z[2]) * $signed(uv2_axis[1]);
      t_in[2] = $signed(z[2]) * $signed(uv2_axis[0]);
      t_in[3] = $signed(z[0]) * $signed(uv2_axis[2]);
      t_in[4] = $signed(z[0]) * $signed(uv2_axis[1]);
      t_in[5] = $signed(z[1]) * $signed(uv2_axis[0]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = {t_ff[2*i][63], t_ff[2*i]} - {t_ff[2*i+1][63], t_ff[2*i+1]};
      end
   end

   always_comb begin
      logic [64:0] dm;
      logic [64:0] r;
      logic [31:0] c;
      for (int i = 0; i < 3; i++) begin
         dm = d_ff[i][64] ? (~d_ff[i] + 65'd1) : d_ff[i];
         r = (dm + HALF65) >> AXIS_FRAC_BITS;
         c = (r > {33'd0, AXIS_ONE}) ? AXIS_ONE : r[31:0];
         y_in[i] = d_ff[i][64] ? (~c + 32'd1) : c;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         t_ff <= t_in;
         xe_ff <= uv2_axis;
         ze_ff <= uv2_pay[95:0];
         oe_ff <= uv2_pay[191:96];
      end
      if (en_f) begin
         d_ff <= d_in;
         xf_ff <= xe_ff;
         zf_ff <= ze_ff;
         of_ff <= oe_ff;
      end
      if (en_g) begin
         og_ff <= {of_ff[95:64], of_ff[63:32], of_ff[31:0]};
         xg_ff <= xf_ff;
         yg_ff <= y_in;
         zg_ff <= zf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= uv1_out_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
         if (en_d) begin
            vd_ff <= vc_ff;
         end
         if (en_e) begin
            ve_ff <= uv2_out_valid;
         end
         if (en_f) begin
            vf_ff <= ve_ff;
         end
         if (en_g) begin
            vg_ff <= vf_ff;
         end
      end
   end

   assign rsp_chan.valid = vg_ff;
   assign rsp_chan.frame_origin_x = og_ff[2];
   assign rsp_chan.frame_origin_y = og_ff[1];
   assign rsp_chan.frame_origin_z = og_ff[0];
   assign rsp_chan.xaxis_x = xg_ff[0];
   assign rsp_chan.xaxis_y = xg_ff[1];
   assign rsp_chan.xaxis_z = xg_ff[2];
   assign rsp_chan.yaxis_x = yg_ff[0];
   assign rsp_chan.yaxis_y = yg_ff[1];
   assign rsp_chan.yaxis_z = yg_ff[2];
   assign rsp_chan.zaxis_x = zg_ff[0];
   assign rsp_chan.zaxis_y = zg_ff[1];
   assign rsp_chan.zaxis_z = zg_ff[2];

endmodule

// ----- tb/sv/tb_pff_if.sv -----
`timescale 1ns / 100ps
// Constants shared by the testbench of the plane frame unit.
package tb_pff_util_pkg;

   localparam int FRAME_AXIS_BITS = 30;

endpackage

// ----- tb/sv/tb_plane_frame_from_normal_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the plane frame unit: predicts each frame and compares it.
module tb_plane_frame_from_normal_unit;

   localparam int AXB = tb_pff_util_pkg::FRAME_AXIS_BITS;
   localparam longint ONE = 64'sd1 << AXB;
   localparam int LATENCY = 2 * AXB + 89;
   localparam int WATCHDOG_LIMIT = 40 * LATENCY + 2000;

   typedef struct packed {
      pff_pkg::coord_type ox, oy, oz, nx, ny, nz;
   } plane_item_type;

   typedef struct packed {
      pff_pkg::coord_type ox, oy, oz, xx, xy, xz, yx, yy, yz, zx, zy, zz;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   pff_req_if req_chan ();
   pff_rsp_if rsp_chan ();

   plane_frame_from_normal_unit #(.AXIS_FRAC_BITS(AXB)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   frame_type expected_frames[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_axis(longint p);
      longint unsigned m;
      m = (magnitude(p) + (64'd1 << (AXB - 1))) >> AXB;
      return p < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp_axis(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic void normalize(input longint v[3], output longint o[3]);
      longint unsigned m[3], mx, s, len, q;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o[0] = 0; o[1] = 0; o[2] = ONE;
         return;
      end
      while (mx > (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      for (int i = 0; i < 3; i++) s += m[i] * m[i];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << AXB) + (len >> 1)) / len;
         if (q > ONE) q = ONE;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic frame_type build_frame(plane_item_type it);
      longint n[3], z[3], p[3], x[3], y[3];
      pff_pkg::axis_sel_type ref_axis;
      frame_type f;
      n[0] = it.nx; n[1] = it.ny; n[2] = it.nz;
      normalize(n, z);
      if (magnitude(z[0]) <= magnitude(z[1]) && magnitude(z[0]) <= magnitude(z[2]))
         ref_axis = pff_pkg::AXIS_X;
      else if (magnitude(z[1]) <= magnitude(z[2]))
         ref_axis = pff_pkg::AXIS_Y;
      else
         ref_axis = pff_pkg::AXIS_Z;
      for (int i = 0; i < 3; i++)
         p[i] = (i == int'(ref_axis) ? ONE : 0) - round_axis(z[ref_axis] * z[i]);
      normalize(p, x);
      y[0] = clamp_axis(round_axis(z[1] * x[2] - z[2] * x[1]));
      y[1] = clamp_axis(round_axis(z[2] * x[0] - z[0] * x[2]));
      y[2] = clamp_axis(round_axis(z[0] * x[1] - z[1] * x[0]));
      f.ox = it.ox; f.oy = it.oy; f.oz = it.oz;
      f.xx = pff_pkg::coord_type'(x[0]);
      f.xy = pff_pkg::coord_type'(x[1]);
      f.xz = pff_pkg::coord_type'(x[2]);
      f.yx = pff_pkg::coord_type'(y[0]);
      f.yy = pff_pkg::coord_type'(y[1]);
      f.yz = pff_pkg::coord_type'(y[2]);
      f.zx = pff_pkg::coord_type'(z[0]);
      f.zy = pff_pkg::coord_type'(z[1]);
      f.zz = pff_pkg::coord_type'(z[2]);
      return f;
   endfunction

   task automatic send_plane(plane_item_type it);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.origin_x <= it.ox;
      req_chan.origin_y <= it.oy;
      req_chan.origin_z <= it.oz;
      req_chan.normal_x <= it.nx;
      req_chan.normal_y <= it.ny;
      req_chan.normal_z <= it.nz;
      do @(posedge clock); while (!req_chan.ready);
      expected_frames.push_back(build_frame(it));
      sent++;
      @(negedge clock);
   endtask

   function automatic pff_pkg::coord_type rand_coord();
      case ($urandom_range(5))
         0: return pff_pkg::coord_type'($urandom_range(65536 * 4));
         1: return -pff_pkg::coord_type'($urandom_range(65536 * 4));
         2: return pff_pkg::coord_type'($urandom_range(16));
         3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return pff_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic plane_item_type rand_plane();
      plane_item_type it;
      it.ox = $urandom; it.oy = $urandom; it.oz = $urandom;
      it.nx = rand_coord(); it.ny = rand_coord(); it.nz = rand_coord();
      case ($urandom_range(7))
         0: it.nx = it.ny;
         1: begin it.ny = it.nz; it.nx = it.nz; end
         2: it.nx = '0;
         default: ;
      endcase
      return it;
   endfunction

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      pff_pkg::coord_type v[8] = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000, 65536, -65536, 3};
      plane_item_type it;
      send_plane('{32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0});
      send_plane('{-1, 1, 65536, 0, 0, 65536});
      send_plane('{0, 0, 0, 65536, 0, 0});
      send_plane('{0, 0, 0, 0, -65536, 0});
      send_plane('{0, 0, 0, 65536, 65536, 65536});
      send_plane('{0, 0, 0, -65536, -65536, -65536});
      send_plane('{0, 0, 0, 65536, 65536, 0});
      send_plane('{0, 0, 0, 0, 65536, 65536});
      send_plane('{0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000});
      send_plane('{0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
      send_plane('{0, 0, 0, 1, 0, 0});
      send_plane('{0, 0, 0, 1, 1, 1});
      for (int i = 0; i < 8; i++) begin
         it = '{$urandom, $urandom, $urandom, v[i], v[(i + 3) % 8], v[(i + 5) % 8]};
         send_plane(it);
      end
      drain();
   endtask

   task automatic test_random(int count, int idle, int stall);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) send_plane(rand_plane());
      drain();
   endtask

   always @(negedge clock)
      rsp_chan.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      frame_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.frame_origin_x, rsp_chan.frame_origin_y, rsp_chan.frame_origin_z,
                 rsp_chan.xaxis_x, rsp_chan.xaxis_y, rsp_chan.xaxis_z,
                 rsp_chan.yaxis_x, rsp_chan.yaxis_y, rsp_chan.yaxis_z,
                 rsp_chan.zaxis_x, rsp_chan.zaxis_y, rsp_chan.zaxis_z};
         received++;
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected frame %h", $time, got);
            errors++;
         end else begin
            want = expected_frames.pop_front();
            for (int i = 0; i < 12; i++)
               if (got[32*i +: 32] != want[32*i +: 32]) begin
                  $display("%0t: field %0d expected %0d actual %0d", $time, 11 - i,
                           $signed(want[32*i +: 32]), $signed(got[32*i +: 32]));
                  errors++;
               end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d frames outstanding", expected_frames.size());
         $display("tb_plane_frame_from_normal_unit failed");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.origin_x = '0; req_chan.origin_y = '0; req_chan.origin_z = '0;
      req_chan.normal_x = '0; req_chan.normal_y = '0; req_chan.normal_z = '0;
      rsp_chan.ready = 1'b1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(140, 0, 0);
      test_random(130, 56, 0);
      test_random(130, 0, 56);
      test_random(130, 31, 31);
      test_random(20, 0, 0);
      repeat (LATENCY + 10) @(negedge clock);
      $display("Sent %0d planes (directed extremes, ties, zero normal, random) and", sent);
      $display("checked %0d frames under mixed sender gaps and receiver stalls.", received);
      if (errors == 0 && expected_frames.size() == 0)
         $display("tb_plane_frame_from_normal_unit passed");
      else
         $display("tb_plane_frame_from_normal_unit failed");
      $finish;
   end

endmodule
